@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/ukol_pkg.sv @@
`default_nettype none

package ukol_pkg;

    localparam int KEY_W  = 30;
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_UPDATE  = 3'd4,
        OP_DISPLAY = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADPOS   = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_BADOP    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        C_HOLD       = 3'd0,
        C_LOAD       = 3'd1,
        C_FROM_RIGHT = 3'd2,
        C_FROM_LEFT  = 3'd3,
        C_FROM_HEAD  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctl_t;

    typedef struct packed {
        logic key_hit;
        logic nkey_hit;
    } cell_hit_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DISP = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ design/ukol_cell.sv @@
`default_nettype none

module ukol_cell
    import ukol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic             live,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic [KEY_W-1:0] cmp_nkey,
    input  logic [KEY_W-1:0] load_val,
    input  logic [KEY_W-1:0] left,
    input  logic [KEY_W-1:0] right,
    input  logic [KEY_W-1:0] head,
    output logic [KEY_W-1:0] entry,
    output cell_hit_t        hit
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    cell_hit_t        hit_reg;
    cell_hit_t        hit_next;

    always_comb
    begin
        unique case (ctl.op)
            C_HOLD:       entry_next = entry_reg;
            C_LOAD:       entry_next = load_val;
            C_FROM_RIGHT: entry_next = right;
            C_FROM_LEFT:  entry_next = left;
            C_FROM_HEAD:  entry_next = head;
            default:      entry_next = entry_reg;
        endcase
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.cmp_en)
        begin
            hit_next.key_hit  = live && (entry_reg == cmp_key);
            hit_next.nkey_hit = live && (entry_reg == cmp_nkey);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

@@ design/unique_key_ordered_list_core.sv @@
// channel | signals                                        | transfer when
// --------+------------------------------------------------+---------------------
// in      | in_valid in_ready operation key new_key position | in_valid & in_ready
// out     | out_valid out_ready status found_position       | out_valid & out_ready
//         | entry_value entry_count last                    |
//
// Each list slot is a cell; all cells compare the incoming key in the
// transfer cycle, and the execute state, once the output is free, shifts,
// loads or holds every cell. Display gives one result per cycle while the
// output is free, as the cells rotate toward cell 0.
// Reset clears the count, control and cell hit flags only; no clearing pass.
// A full output register stalls execution; in_ready is high only when idle.
`default_nettype none

module unique_key_ordered_list_core
    import ukol_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [KEY_W-1:0]  key,
    input  logic [KEY_W-1:0]  new_key,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic [FPOS_W-1:0] found_position,
    output logic [KEY_W-1:0]  entry_value,
    output logic [CNT_W-1:0]  entry_count,
    output logic              last
);

`include "assert_macros.svh"

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IW-1:0]     disp_idx_reg;
    logic [IW-1:0]     disp_idx_next;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  nkey_reg;
    logic [POS_W-1:0]  pos_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [FPOS_W-1:0] fpos_reg;
    logic [KEY_W-1:0]  value_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic              last_reg;

    logic              out_load;
    status_t           st_res;
    logic [FPOS_W-1:0] fpos_res;
    logic [KEY_W-1:0]  value_res;
    logic              last_res;

    logic              accept;
    logic              out_free;
    logic              hit_key;
    logic              hit_nkey;
    logic [IW-1:0]     at;
    logic [KEY_W-1:0]  load_val;

    cell_ctl_t         ctl       [CAPACITY];
    cell_hit_t         hits      [CAPACITY];
    logic [KEY_W-1:0]  entry_w   [CAPACITY];
    logic [CAPACITY-1:0] key_hit_vec;
    logic [CAPACITY-1:0] nkey_hit_vec;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign load_val = (op_reg == OP_UPDATE) ? nkey_reg : key_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_W-1:0] left_w;
            logic [KEY_W-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = entry_w[g];
            end
            else
            begin : g_mid_l
                assign left_w = entry_w[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_w = entry_w[g];
            end
            else
            begin : g_mid_r
                assign right_w = entry_w[g+1];
            end

            ukol_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[g]),
                .live     (CW'(g) < count_reg),
                .cmp_key  (key),
                .cmp_nkey (new_key),
                .load_val (load_val),
                .left     (left_w),
                .right    (right_w),
                .head     (entry_w[0]),
                .entry    (entry_w[g]),
                .hit      (hits[g])
            );

            assign key_hit_vec[g]  = hits[g].key_hit;
            assign nkey_hit_vec[g] = hits[g].nkey_hit;
        end
    endgenerate

    assign hit_key  = |key_hit_vec;
    assign hit_nkey = |nkey_hit_vec;

    always_comb
    begin
        at = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (key_hit_vec[i])
            begin
                at = at | IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        disp_idx_next = disp_idx_reg;
        out_load      = 1'b0;
        st_res        = ST_OK;
        fpos_res      = '0;
        value_res     = '0;
        last_res      = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctl[i].op     = C_HOLD;
            ctl[i].cmp_en = accept;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                st_res = ST_FULL;
                            end
                            else if (hit_key)
                            begin
                                st_res = ST_DUP;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (CW'(i) == count_reg)
                                    begin
                                        ctl[i].op = C_LOAD;
                                    end
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!hit_key)
                            begin
                                st_res = ST_NOTFOUND;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (IW'(i) >= at)
                                    begin
                                        ctl[i].op = C_FROM_RIGHT;
                                    end
                                end
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                st_res = ST_FULL;
                            end
                            else if (pos_reg > POS_W'(count_reg))
                            begin
                                st_res = ST_BADPOS;
                            end
                            else if (hit_key)
                            begin
                                st_res = ST_DUP;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (POS_W'(i) == pos_reg)
                                    begin
                                        ctl[i].op = C_LOAD;
                                    end
                                    else if (POS_W'(i) > pos_reg)
                                    begin
                                        ctl[i].op = C_FROM_LEFT;
                                    end
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (!hit_key)
                            begin
                                st_res = ST_NOTFOUND;
                            end
                            else
                            begin
                                fpos_res = FPOS_W'(at);
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (hit_nkey)
                            begin
                                st_res = ST_DUP;
                            end
                            else if (!hit_key)
                            begin
                                st_res = ST_NOTFOUND;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (IW'(i) == at)
                                    begin
                                        ctl[i].op = C_LOAD;
                                    end
                                end
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                st_res = ST_EMPTY;
                            end
                            else
                            begin
                                out_load      = 1'b0;
                                state_next    = S_DISP;
                                disp_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            st_res = ST_BADOP;
                        end
                    endcase
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    value_res     = entry_w[0];
                    last_res      = (CW'(disp_idx_reg) == count_reg - CW'(1));
                    disp_idx_next = disp_idx_reg + IW'(1);
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CW'(i) == count_reg - CW'(1))
                        begin
                            ctl[i].op = C_FROM_HEAD;
                        end
                        else if (CW'(i) < count_reg)
                        begin
                            ctl[i].op = C_FROM_RIGHT;
                        end
                    end
                    if (last_res)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            disp_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            disp_idx_reg <= disp_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            nkey_reg <= new_key;
            pos_reg  <= position;
        end
        if (out_load)
        begin
            status_reg  <= st_res;
            fpos_reg    <= fpos_res;
            value_reg   <= value_res;
            cnt_out_reg <= CNT_W'(count_next);
            last_reg    <= last_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign entry_value    = value_reg;
    assign entry_count    = cnt_out_reg;
    assign last           = last_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY), "count exceeds capacity")
    `ASSERT_ALWAYS(a_keys_unique, clk, rst_n, $onehot0(key_hit_vec), "key matches several cells")
    `ASSERT_IMPLY(a_disp_nonempty, clk, rst_n, state_reg == S_DISP, count_reg != '0, "display on empty list")
    `ASSERT_IMPLY(a_count_from_exec, clk, rst_n, !$stable(count_reg), $past(state_reg) == S_EXEC, "count changed outside execute")

endmodule

`default_nettype wire
